// ----- hw/rtl/nldm_pkg.sv -----
// ----------------------------------------------------------------------------
// nldm_pkg
// Shared constants, field layout, op codes and the request/write records that
// pass from the lookup front end to the per-table interpolation datapath.
// ----------------------------------------------------------------------------
package nldm_pkg;

  localparam int TABLE_DIM   = 7;
  localparam int VALUE_BITS  = 24;
  localparam int FIELD_IDX_W = 3;
  localparam int OP_W        = 3;

  localparam int AIDX_W = $clog2(TABLE_DIM);
  localparam int CNT_W  = $clog2(TABLE_DIM + 1);
  localparam int CELLS  = TABLE_DIM * TABLE_DIM;
  localparam int ADDR_W = $clog2(CELLS);

  // signed difference of two values, product of two differences
  localparam int DIF_W = VALUE_BITS + 1;
  localparam int PRD_W = 2 * DIF_W;
  // quotient bits kept before saturation
  localparam int Q_W   = VALUE_BITS + 1;
  // register stages inside the interpolation datapath
  localparam int INTERP_LAT = 7 + Q_W;

  localparam int IN_RAW_W   = 2 * FIELD_IDX_W + 3 * VALUE_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * VALUE_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_WR_SLEW_AXIS = OP_W'(0);
  localparam logic [OP_W-1:0] OP_WR_LOAD_AXIS = OP_W'(1);
  localparam logic [OP_W-1:0] OP_WR_DELAY     = OP_W'(2);
  localparam logic [OP_W-1:0] OP_WR_OSLEW     = OP_W'(3);
  localparam logic [OP_W-1:0] OP_QUERY        = OP_W'(4);

  typedef logic [VALUE_BITS-1:0]   val_t;
  typedef logic signed [DIF_W-1:0] dif_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a11;
    logic [ADDR_W-1:0] a12;
    logic [ADDR_W-1:0] a21;
    logic [ADDR_W-1:0] a22;
    dif_t              da;   // c2 - c
    dif_t              db;   // c - c1
    dif_t              de;   // t2 - s
    dif_t              df;   // s - t1
    dif_t              dc;   // c2 - c1
    dif_t              dt;   // t2 - t1
    logic              corner;
    logic              lin_c;
    logic              lin_t;
  } nldm_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    val_t              data;
  } nldm_wr_t;

endpackage

// ----- hw/rtl/nldm_table_bilinear_lookup.sv -----
// throughput: one transaction per cycle unless stalled, any write/query mix
// a result held on the output with out_tready low freezes the whole pipeline
// the divider sets the depth: one quotient bit per stage over 25 stages
// reset clears the valid bits only; axes and tables are undefined until written
// ----------------------------------------------------------------------------
// nldm_table_bilinear_lookup
// Two-axis table lookup: bracket search on the slew and load axes, then
// corner, linear or bilinear interpolation of the delay and slew tables.
// ----------------------------------------------------------------------------
module nldm_table_bilinear_lookup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // row_index, col_index, write_value, query_slew, query_load
  input  logic [nldm_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic [nldm_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // delay_value, output_slew
  output logic [nldm_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import nldm_pkg::*;

  localparam int ROW_LSB = 0;
  localparam int COL_LSB = FIELD_IDX_W;
  localparam int WV_LSB  = 2 * FIELD_IDX_W;
  localparam int SL_LSB  = WV_LSB + VALUE_BITS;
  localparam int LD_LSB  = SL_LSB + VALUE_BITS;

  typedef logic [TABLE_DIM-1:0][VALUE_BITS-1:0] axis_t;

  typedef struct packed {
    logic [AIDX_W-1:0] i1;
    logic [AIDX_W-1:0] i2;
    val_t              x1;
    val_t              x2;
  } brk_t;

  function automatic brk_t bracket(input axis_t ax, input val_t v);
    val_t                 first;
    val_t                 last;
    logic                 lt_last;
    logic                 pick_first;
    logic [TABLE_DIM-1:0] lt;
    logic [TABLE_DIM-1:0] eq;
    logic [CNT_W-1:0]     pos;
    brk_t                 r;
    first      = ax[0];
    last       = ax[TABLE_DIM-1];
    lt_last    = v < last;
    pick_first = lt_last ? (v < first) : (last < first);
    // compare against the clamped value without building it first
    for (int k = 0; k < TABLE_DIM; k++) begin
      if (pick_first) begin
        lt[k] = ax[k] < first;
        eq[k] = ax[k] == first;
      end else if (lt_last) begin
        lt[k] = ax[k] < v;
        eq[k] = ax[k] == v;
      end else begin
        lt[k] = ax[k] < last;
        eq[k] = ax[k] == last;
      end
    end
    pos = CNT_W'(TABLE_DIM);
    for (int k = TABLE_DIM - 1; k >= 0; k--) begin
      if (!lt[k]) begin
        pos = CNT_W'(k);
      end
    end
    if (pos == '0) begin
      r.i1 = '0;
      r.i2 = '0;
    end else if (pos == CNT_W'(TABLE_DIM)) begin
      r.i1 = AIDX_W'(TABLE_DIM - 1);
      r.i2 = AIDX_W'(TABLE_DIM - 1);
    end else begin
      r.i2 = AIDX_W'(pos);
      r.i1 = eq[AIDX_W'(pos)] ? AIDX_W'(pos) : AIDX_W'(pos) - 1'b1;
    end
    r.x1 = '0;
    r.x2 = '0;
    for (int k = 0; k < TABLE_DIM; k++) begin
      if (r.i1 == AIDX_W'(k)) begin
        r.x1 = r.x1 | ax[k];
      end
      if (r.i2 == AIDX_W'(k)) begin
        r.x2 = r.x2 | ax[k];
      end
    end
    return r;
  endfunction

  logic adv;
  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // input register
  logic                   p0_vld_r;
  logic [OP_W-1:0]        p0_op_r;
  logic [FIELD_IDX_W-1:0] p0_row_r, p0_col_r;
  val_t                   p0_wv_r, p0_s_r, p0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (adv) begin
      p0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_op_r  <= in_tuser;
      p0_row_r <= in_tdata[ROW_LSB +: FIELD_IDX_W];
      p0_col_r <= in_tdata[COL_LSB +: FIELD_IDX_W];
      p0_wv_r  <= in_tdata[WV_LSB +: VALUE_BITS];
      p0_s_r   <= in_tdata[SL_LSB +: VALUE_BITS];
      p0_c_r   <= in_tdata[LD_LSB +: VALUE_BITS];
    end
  end

  // axes: every read and write of an axis happens in this one stage
  axis_t slew_axis_r, load_axis_r;
  brk_t  brk_s, brk_c;
  logic  row_ok, col_ok;

  assign brk_s  = bracket(slew_axis_r, p0_s_r);
  assign brk_c  = bracket(load_axis_r, p0_c_r);
  assign row_ok = 32'(p0_row_r) < TABLE_DIM;
  assign col_ok = 32'(p0_col_r) < TABLE_DIM;

  always_ff @(posedge clk) begin
    if (adv && p0_vld_r && row_ok) begin
      if (p0_op_r == OP_WR_SLEW_AXIS) begin
        slew_axis_r[AIDX_W'(p0_row_r)] <= p0_wv_r;
      end
      if (p0_op_r == OP_WR_LOAD_AXIS) begin
        load_axis_r[AIDX_W'(p0_row_r)] <= p0_wv_r;
      end
    end
  end

  logic              p1_q_r, p1_wd_r, p1_wo_r;
  logic [ADDR_W-1:0] p1_addr_r;
  val_t              p1_wv_r, p1_s_r, p1_c_r;
  brk_t              brk_s_r, brk_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_q_r  <= 1'b0;
      p1_wd_r <= 1'b0;
      p1_wo_r <= 1'b0;
    end else if (adv) begin
      p1_q_r  <= p0_vld_r && (p0_op_r == OP_QUERY);
      p1_wd_r <= p0_vld_r && row_ok && col_ok && (p0_op_r == OP_WR_DELAY);
      p1_wo_r <= p0_vld_r && row_ok && col_ok && (p0_op_r == OP_WR_OSLEW);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_addr_r <= ADDR_W'(AIDX_W'(p0_row_r) * TABLE_DIM + AIDX_W'(p0_col_r));
      p1_wv_r   <= p0_wv_r;
      p1_s_r    <= p0_s_r;
      p1_c_r    <= p0_c_r;
      brk_s_r   <= brk_s;
      brk_c_r   <= brk_c;
    end
  end

  // corner addresses, differences and interpolation mode
  nldm_req_t req;
  nldm_wr_t  wr_d, wr_o;

  always_comb begin
    req.a11    = ADDR_W'(brk_s_r.i1 * TABLE_DIM + brk_c_r.i1);
    req.a12    = ADDR_W'(brk_s_r.i1 * TABLE_DIM + brk_c_r.i2);
    req.a21    = ADDR_W'(brk_s_r.i2 * TABLE_DIM + brk_c_r.i1);
    req.a22    = ADDR_W'(brk_s_r.i2 * TABLE_DIM + brk_c_r.i2);
    req.da     = {1'b0, brk_c_r.x2} - {1'b0, p1_c_r};
    req.db     = {1'b0, p1_c_r} - {1'b0, brk_c_r.x1};
    req.de     = {1'b0, brk_s_r.x2} - {1'b0, p1_s_r};
    req.df     = {1'b0, p1_s_r} - {1'b0, brk_s_r.x1};
    req.dc     = {1'b0, brk_c_r.x2} - {1'b0, brk_c_r.x1};
    req.dt     = {1'b0, brk_s_r.x2} - {1'b0, brk_s_r.x1};
    req.corner = (brk_s_r.i1 == brk_s_r.i2) && (brk_c_r.i1 == brk_c_r.i2);
    req.lin_c  = (brk_s_r.i1 == brk_s_r.i2) && (brk_c_r.i1 != brk_c_r.i2);
    req.lin_t  = (brk_s_r.i1 != brk_s_r.i2) && (brk_c_r.i1 == brk_c_r.i2);
    wr_d.en    = p1_wd_r;
    wr_d.addr  = p1_addr_r;
    wr_d.data  = p1_wv_r;
    wr_o.en    = p1_wo_r;
    wr_o.addr  = p1_addr_r;
    wr_o.data  = p1_wv_r;
  end

  val_t res_delay, res_oslew;

  nldm_interp u_delay (
    .clk (clk),
    .adv (adv),
    .wr  (wr_d),
    .req (req),
    .res (res_delay)
  );

  nldm_interp u_oslew (
    .clk (clk),
    .adv (adv),
    .wr  (wr_o),
    .req (req),
    .res (res_oslew)
  );

  // query valid bits track the datapath stages
  logic [INTERP_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[INTERP_LAT-2:0], p1_q_r};
      out_valid_r <= vld_r[INTERP_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= OUT_DATA_W'({res_oslew, res_delay});
    end
  end

`ifndef SYNTHESIS
  a_brk_order: assert property (@(posedge clk) disable iff (!rst_n)
    p1_q_r |-> (brk_s_r.i1 <= brk_s_r.i2) && (brk_c_r.i1 <= brk_c_r.i2))
    else $error("bracket indices out of order");

  a_brk_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    p1_q_r |-> (brk_s_r.i2 == brk_s_r.i1 || brk_s_r.i2 == brk_s_r.i1 + 1'b1) &&
               (brk_c_r.i2 == brk_c_r.i1 || brk_c_r.i2 == brk_c_r.i1 + 1'b1))
    else $error("bracket indices not adjacent");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[INTERP_LAT-1]))
    else $error("result without a query at the end of the pipeline");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !p1_q_r |=> !vld_r[0])
    else $error("write transaction entered the result pipeline");
`endif

endmodule

// ----- hw/rtl/nldm_interp.sv -----
// ----------------------------------------------------------------------------
// nldm_interp
// One table: two memory copies give four corner reads a cycle while adv is
// high, then multiply, sum, and a pipelined restoring divider with saturation.
// ----------------------------------------------------------------------------
module nldm_interp (
  input  logic                clk,
  input  logic                adv,
  input  nldm_pkg::nldm_wr_t  wr,
  input  nldm_pkg::nldm_req_t req,
  output nldm_pkg::val_t      res
);
  import nldm_pkg::*;

  localparam int LO_W  = VALUE_BITS + DIF_W;
  localparam int HI_W  = VALUE_BITS + 1 + DIF_W;
  localparam int SLO_W = LO_W + 2;
  localparam int SHI_W = HI_W + 2;
  localparam int NUM_W = SHI_W + DIF_W;
  localparam int RES_W = VALUE_BITS + 3;

  typedef logic signed [PRD_W-1:0] prd_t;

  typedef struct packed {
    logic [PRD_W-1:0] rem;
    logic [Q_W-1:0]   nlow;
    logic [Q_W-1:0]   quo;
    logic [PRD_W-1:0] dmag;
    logic             neg;
    logic             ovf;
    logic             pick;
    logic             lin;
    val_t             v11;
  } dstage_t;

  // table memories and registered corner reads
  val_t      mem_a_r [CELLS];
  val_t      mem_b_r [CELLS];
  val_t      v11_r, v12_r, v21_r, v22_r;
  nldm_req_t req_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr.en) begin
        mem_a_r[wr.addr] <= wr.data;
        mem_b_r[wr.addr] <= wr.data;
      end
      v11_r <= mem_a_r[req.a11];
      v12_r <= mem_a_r[req.a12];
      v21_r <= mem_b_r[req.a21];
      v22_r <= mem_b_r[req.a22];
      req_r <= req;
    end
  end

  // products of differences
  prd_t ae_r, be_r, af_r, bf_r, dd_r, plin_r;
  dif_t dlin_r;
  val_t w_r [4];
  logic corner3_r, lin3_r;
  dif_t dv, dx;
  val_t vb;

  always_comb begin
    vb = req_r.lin_c ? v12_r : v21_r;
    dv = {1'b0, vb} - {1'b0, v11_r};
    dx = req_r.lin_c ? req_r.db : req_r.df;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ae_r      <= req_r.da * req_r.de;
      be_r      <= req_r.db * req_r.de;
      af_r      <= req_r.da * req_r.df;
      bf_r      <= req_r.db * req_r.df;
      dd_r      <= req_r.dc * req_r.dt;
      plin_r    <= dv * dx;
      dlin_r    <= req_r.lin_c ? req_r.dc : req_r.dt;
      w_r[0]    <= v11_r;
      w_r[1]    <= v12_r;
      w_r[2]    <= v21_r;
      w_r[3]    <= v22_r;
      corner3_r <= req_r.corner;
      lin3_r    <= req_r.lin_c | req_r.lin_t;
    end
  end

  // corner value times product, split in two halves of the product
  logic [LO_W-1:0]        lo_r [4];
  logic signed [HI_W-1:0] hi_r [4];
  prd_t pp [4];
  prd_t plin4_r, dd4_r;
  dif_t dlin4_r;
  val_t v11_4_r;
  logic corner4_r, lin4_r;

  always_comb begin
    pp[0] = ae_r;
    pp[1] = be_r;
    pp[2] = af_r;
    pp[3] = bf_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        lo_r[k] <= LO_W'(w_r[k]) * LO_W'(pp[k][DIF_W-1:0]);
        hi_r[k] <= $signed({1'b0, w_r[k]}) * $signed(pp[k][PRD_W-1:DIF_W]);
      end
      plin4_r   <= plin_r;
      dd4_r     <= dd_r;
      dlin4_r   <= dlin_r;
      v11_4_r   <= w_r[0];
      corner4_r <= corner3_r;
      lin4_r    <= lin3_r;
    end
  end

  // sums of the four terms
  logic [SLO_W-1:0]        slo_r;
  logic signed [SHI_W-1:0] shi_r;
  logic signed [SHI_W-1:0] hacc;
  prd_t plin5_r, dd5_r;
  dif_t dlin5_r;
  val_t v11_5_r;
  logic corner5_r, lin5_r;

  always_comb begin
    hacc = hi_r[0];
    hacc = hacc + hi_r[1];
    hacc = hacc + hi_r[2];
    hacc = hacc + hi_r[3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slo_r     <= SLO_W'(lo_r[0]) + SLO_W'(lo_r[1]) + SLO_W'(lo_r[2]) + SLO_W'(lo_r[3]);
      shi_r     <= hacc;
      plin5_r   <= plin4_r;
      dd5_r     <= dd4_r;
      dlin5_r   <= dlin4_r;
      v11_5_r   <= v11_4_r;
      corner5_r <= corner4_r;
      lin5_r    <= lin4_r;
    end
  end

  // numerator and denominator select
  logic signed [NUM_W-1:0] nb, nl, num6_r;
  prd_t dl, den, den6_r;
  val_t v11_6_r;
  logic pick6_r, lin6_r;

  always_comb begin
    nb  = shi_r;
    nb  = (nb <<< DIF_W) + $signed({1'b0, slo_r});
    nl  = plin5_r;
    dl  = dlin5_r;
    den = lin5_r ? dl : dd5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num6_r  <= lin5_r ? nl : nb;
      den6_r  <= den;
      pick6_r <= corner5_r | (den == '0);
      lin6_r  <= lin5_r;
      v11_6_r <= v11_5_r;
    end
  end

  // magnitudes and result sign
  logic [NUM_W-1:0] nmag_r;
  logic [PRD_W-1:0] dmag_r;
  logic             neg7_r, pick7_r, lin7_r;
  val_t             v11_7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r  <= num6_r[NUM_W-1] ? NUM_W'(-num6_r) : NUM_W'(num6_r);
      dmag_r  <= den6_r[PRD_W-1] ? PRD_W'(-den6_r) : PRD_W'(den6_r);
      neg7_r  <= num6_r[NUM_W-1] ^ den6_r[PRD_W-1];
      pick7_r <= pick6_r;
      lin7_r  <= lin6_r;
      v11_7_r <= v11_6_r;
    end
  end

  // restoring divider, one quotient bit per stage
  dstage_t          div_r   [Q_W+1];
  dstage_t          div_nxt [Q_W+1];
  logic [PRD_W:0]   tmp;
  logic             ge;

  always_comb begin
    div_nxt[0].rem  = PRD_W'(nmag_r >> Q_W);
    div_nxt[0].nlow = nmag_r[Q_W-1:0];
    div_nxt[0].quo  = '0;
    div_nxt[0].dmag = dmag_r;
    div_nxt[0].neg  = neg7_r;
    // quotient would not fit in the kept bits
    div_nxt[0].ovf  = nmag_r >= NUM_W'({dmag_r, {Q_W{1'b0}}});
    div_nxt[0].pick = pick7_r;
    div_nxt[0].lin  = lin7_r;
    div_nxt[0].v11  = v11_7_r;
    tmp = '0;
    ge  = 1'b0;
    for (int k = 1; k <= Q_W; k++) begin
      div_nxt[k] = div_r[k-1];
      tmp = {div_r[k-1].rem, div_r[k-1].nlow[Q_W-1]};
      ge  = tmp >= {1'b0, div_r[k-1].dmag};
      div_nxt[k].rem  = ge ? PRD_W'(tmp - {1'b0, div_r[k-1].dmag}) : PRD_W'(tmp);
      div_nxt[k].nlow = div_r[k-1].nlow << 1;
      div_nxt[k].quo  = {div_r[k-1].quo[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= Q_W; k++) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // apply sign and base, saturate
  logic signed [RES_W-1:0] sv;
  logic signed [RES_W-1:0] qext;

  always_comb begin
    sv   = div_r[Q_W].lin ? $signed({3'b000, div_r[Q_W].v11}) : '0;
    qext = $signed({2'b00, div_r[Q_W].quo});
    sv   = div_r[Q_W].neg ? sv - qext : sv + qext;
    if (div_r[Q_W].pick) begin
      res = div_r[Q_W].v11;
    end else if (div_r[Q_W].ovf) begin
      res = div_r[Q_W].neg ? '0 : '1;
    end else if (sv[RES_W-1]) begin
      res = '0;
    end else if (|sv[RES_W-2:VALUE_BITS]) begin
      res = '1;
    end else begin
      res = sv[VALUE_BITS-1:0];
    end
  end

endmodule

// ----- tb/tb_nldm_table_bilinear_lookup.sv -----
// ----------------------------------------------------------------------------
// tb_nldm_table_bilinear_lookup
// Loads axes and tables through the input stream, then issues queries and
// compares each interpolated delay and output slew against a local predictor.
// ----------------------------------------------------------------------------
module tb_nldm_table_bilinear_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import nldm_pkg::*;

  localparam int N = TABLE_DIM;
  localparam longint unsigned VMAX = (64'd1 << VALUE_BITS) - 1;
  localparam int LIMIT = 400000;

  // codes outside the defined operations
  localparam logic [OP_W-1:0] OP_BAD_LO = OP_W'(5);
  localparam logic [OP_W-1:0] OP_BAD_HI = OP_W'(7);

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [2:0]        row;
    logic [2:0]        col;
    val_t              wval;
    val_t              qs;
    val_t              ql;
  } txn_t;

  typedef struct {
    val_t dly;
    val_t osl;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  always #1 clk = ~clk;

  nldm_table_bilinear_lookup u_top (.*);

  // predictor state
  longint unsigned slew_ax [N];
  longint unsigned load_ax [N];
  longint unsigned dly_tab [N*N];
  longint unsigned osl_tab [N*N];

  txn_t pending_q[$];
  res_t result_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   hold_cycles = 0;
  bit   stim_done = 0;
  int   in_gap = 0;
  int   out_gap = 0;

  function automatic void find_bracket(input bit use_slew, input longint unsigned v,
                                       output int i1, output int i2);
    longint unsigned ax [N];
    longint unsigned x;
    int i;
    for (int k = 0; k < N; k++) ax[k] = use_slew ? slew_ax[k] : load_ax[k];
    x = (v < ax[N-1]) ? v : ax[N-1];
    if (x < ax[0]) x = ax[0];
    i = 0;
    while (i < N && ax[i] < x) i++;
    if (i == 0) begin
      i1 = 0; i2 = 0;
    end else if (i == N) begin
      i1 = N-1; i2 = N-1;
    end else begin
      i2 = i;
      i1 = (ax[i] == x) ? i : i - 1;
    end
  endfunction

  function automatic longint unsigned sat(input logic signed [127:0] x);
    if (x < 0) return 0;
    if (x > VMAX) return VMAX;
    return x[63:0];
  endfunction

  // truncating division of signed values
  function automatic logic signed [127:0] tdiv(input logic signed [127:0] n,
                                               input logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint unsigned lerp(input longint unsigned va, vb, x, x1, x2);
    logic signed [127:0] den, num;
    den = $signed({64'd0, x2}) - $signed({64'd0, x1});
    if (den == 0) return va;
    num = ($signed({64'd0, vb}) - $signed({64'd0, va})) *
          ($signed({64'd0, x}) - $signed({64'd0, x1}));
    return sat($signed({64'd0, va}) + tdiv(num, den));
  endfunction

  function automatic longint unsigned interp(input bit use_dly, input longint unsigned s, c);
    int ti1, ti2, ci1, ci2;
    longint unsigned t1, t2, c1, c2, v11, v12, v21, v22;
    logic signed [127:0] a, b, e, f, dc, dt, num;
    find_bracket(1, s, ti1, ti2);
    find_bracket(0, c, ci1, ci2);
    t1 = slew_ax[ti1]; t2 = slew_ax[ti2];
    c1 = load_ax[ci1]; c2 = load_ax[ci2];
    v11 = use_dly ? dly_tab[ti1*N+ci1] : osl_tab[ti1*N+ci1];
    v12 = use_dly ? dly_tab[ti1*N+ci2] : osl_tab[ti1*N+ci2];
    v21 = use_dly ? dly_tab[ti2*N+ci1] : osl_tab[ti2*N+ci1];
    v22 = use_dly ? dly_tab[ti2*N+ci2] : osl_tab[ti2*N+ci2];
    if (ti1 == ti2 && ci1 == ci2) return v11;
    if (ti1 == ti2) return lerp(v11, v12, c, c1, c2);
    if (ci1 == ci2) return lerp(v11, v21, s, t1, t2);
    dc = $signed({64'd0, c2}) - $signed({64'd0, c1});
    dt = $signed({64'd0, t2}) - $signed({64'd0, t1});
    if (dc == 0 || dt == 0) return v11;
    a = $signed({64'd0, c2}) - $signed({64'd0, c});
    b = $signed({64'd0, c}) - $signed({64'd0, c1});
    e = $signed({64'd0, t2}) - $signed({64'd0, s});
    f = $signed({64'd0, s}) - $signed({64'd0, t1});
    num = $signed({64'd0, v11}) * a * e + $signed({64'd0, v12}) * b * e
        + $signed({64'd0, v21}) * a * f + $signed({64'd0, v22}) * b * f;
    return sat(tdiv(num, dc * dt));
  endfunction

  // apply one accepted transaction to the predictor
  function automatic void predict_lookup(input txn_t t);
    res_t r;
    if (t.op == OP_QUERY) begin
      r.dly = val_t'(interp(1, t.qs, t.ql));
      r.osl = val_t'(interp(0, t.qs, t.ql));
      result_q.push_back(r);
    end else if (t.row < N) begin
      case (t.op)
        OP_WR_SLEW_AXIS: slew_ax[t.row] = t.wval;
        OP_WR_LOAD_AXIS: load_ax[t.row] = t.wval;
        OP_WR_DELAY:     if (t.col < N) dly_tab[t.row*N+t.col] = t.wval;
        OP_WR_OSLEW:     if (t.col < N) osl_tab[t.row*N+t.col] = t.wval;
        default: ;
      endcase
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic txn_t mk(input logic [OP_W-1:0] op, input int row, col,
                              input longint unsigned wv, qs, ql);
    txn_t t;
    t.op = op; t.row = row[2:0]; t.col = col[2:0];
    t.wval = val_t'(wv); t.qs = val_t'(qs); t.ql = val_t'(ql);
    return t;
  endfunction

  function automatic val_t rval();
    return val_t'($urandom());
  endfunction

  // fill all axes and tables; mode 0 stepped from a base, 1 random order, 2 flat
  task automatic load_tables(input int mode);
    longint unsigned base, v;
    base = $urandom_range(0, 4000);
    for (int k = 0; k < N; k++) begin
      case (mode)
        0: v = base + k * $urandom_range(1, 30000) + k;
        1: v = rval();
        default: v = base;
      endcase
      if (mode == 0 && k == N-1 && $urandom_range(0, 3) == 0) v = VMAX;
      pending_q.push_back(mk(OP_WR_SLEW_AXIS, k, $urandom_range(0, 7), v & VMAX,
                             rval(), rval()));
      v = (mode == 1) ? rval() : (mode == 2 ? base : base * 2 + k * $urandom_range(1, 50000));
      pending_q.push_back(mk(OP_WR_LOAD_AXIS, k, $urandom_range(0, 7), v & VMAX,
                             rval(), rval()));
    end
    for (int r = 0; r < N; r++)
      for (int c = 0; c < N; c++) begin
        pending_q.push_back(mk(OP_WR_DELAY, r, c, $urandom_range(0, 3) == 0 ? VMAX : rval(),
                               rval(), rval()));
        pending_q.push_back(mk(OP_WR_OSLEW, r, c, $urandom_range(0, 5) == 0 ? 0 : rval(),
                               rval(), rval()));
      end
  endtask

  function automatic longint unsigned near_axis(input bit use_slew);
    longint unsigned v;
    int k;
    k = $urandom_range(0, N-1);
    v = use_slew ? slew_ax[k] : load_ax[k];
    case ($urandom_range(0, 5))
      0: return v;
      1: return (v + $urandom_range(0, 5000)) & VMAX;
      2: return v > 100 ? v - $urandom_range(0, 100) : 0;
      3: return 0;
      4: return VMAX;
      default: return rval();
    endcase
  endfunction

  task automatic add_queries(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        pending_q.push_back(mk(OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI)),
                               $urandom_range(0, 7), $urandom_range(0, 7),
                               rval(), rval(), rval()));
      else if ($urandom_range(0, 9) == 0)
        pending_q.push_back(mk(OP_W'($urandom_range(OP_WR_SLEW_AXIS, OP_WR_OSLEW)), 7,
                               $urandom_range(0, 7), rval(), rval(), rval()));
      else if ($urandom_range(0, 9) == 0)
        pending_q.push_back(mk(OP_WR_DELAY, $urandom_range(0, 6), 7,
                               rval(), rval(), rval()));
      pending_q.push_back(mk(OP_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
                             rval(), near_axis(1), near_axis(0)));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_lookup(pending_q.pop_front());
        in_gap = pick_gap();
      end else if (!in_tvalid && in_gap > 0) begin
        in_gap--;
      end
      if (pending_q.size() > 0 && (in_tvalid && !in_tready || in_gap == 0)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_q[0].op;
        in_tdata  <= IN_DATA_W'({pending_q[0].ql, pending_q[0].qs, pending_q[0].wval,
                                 pending_q[0].col, pending_q[0].row});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    val_t got_d, got_s;
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_d = out_tdata[VALUE_BITS-1:0];
        got_s = out_tdata[2*VALUE_BITS-1:VALUE_BITS];
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: delay_value %0h output_slew %0h",
                 got_d, got_s);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got_d !== want.dly) begin
            $error("delay_value expected %0h actual %0h", want.dly, got_d);
            errors++;
          end
          if (got_s !== want.osl) begin
            $error("output_slew expected %0h actual %0h", want.osl, got_s);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_gap = (cycles % 3000 < 1000) ? 0 : pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int k = 0; k < N; k++) begin
      slew_ax[k] = 0; load_ax[k] = 0;
    end
    for (int k = 0; k < N*N; k++) begin
      dly_tab[k] = 0; osl_tab[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: mode 0 tables, extremes, exact hits, out of range
    load_tables(0);
    pending_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(OP_QUERY, 7, 7, VMAX, VMAX, VMAX));
    pending_q.push_back(mk(OP_QUERY, 0, 0, 0, VMAX, 0));
    pending_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, VMAX));
    pending_q.push_back(mk(OP_BAD_LO, 7, 7, VMAX, VMAX, VMAX));
    pending_q.push_back(mk(OP_BAD_HI, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(OP_WR_OSLEW, 3, 7, VMAX, 0, 0));
    pending_q.push_back(mk(OP_WR_LOAD_AXIS, 7, 0, 0, 0, 0));
    while (pending_q.size() > 0) @(posedge clk);
    for (int k = 0; k < N; k++) begin
      pending_q.push_back(mk(OP_QUERY, 0, 0, 0, slew_ax[k], load_ax[k]));
      pending_q.push_back(mk(OP_QUERY, 0, 0, 0, slew_ax[k] + 1, load_ax[(k+3)%N] + 7));
    end

    // receiver holds off while the sender keeps offering queries
    while (pending_q.size() > 0) @(posedge clk);
    hold_cycles = 200;
    add_queries(60);

    for (int phase = 0; phase < 3; phase++) begin
      load_tables(phase == 0 ? 1 : (phase == 1 ? 2 : 0));
      add_queries(30);
      while (pending_q.size() > 0) @(posedge clk);
    end
    while (in_tvalid) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    int tail;
    tail = 0;
    while (!(stim_done && result_q.size() == 0) || tail < 100) begin
      @(posedge clk);
      if (stim_done && result_q.size() == 0) tail++;
      if (cycles > LIMIT) begin
        $display("nldm_table_bilinear_lookup: mismatch");
        $finish;
      end
    end
    if (errors == 0)
      $display("nldm_table_bilinear_lookup: match");
    else
      $display("nldm_table_bilinear_lookup: mismatch");
    $finish;
  end
endmodule
